[rtl/rtsm_pkg.sv]
`timescale 1ns / 1ps
package rtsm_pkg;

    localparam int OFF_W = 11;
    localparam logic [OFF_W-1:0] OFFSET_MAX = 11'd2047;
    localparam logic [6:0] RTP_HDR_BASE = 7'd12;
    localparam logic [7:0] SYNC_BYTE = 8'h47;
    localparam int TABLE_START = 13;
    localparam logic [3:0] ZERO_LIMIT = 4'd10;
    localparam logic [3:0] TABLE_DONE = 4'd15;
    localparam int PID_W = 13;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_beat;

    typedef struct packed {
        logic [31:0]      byte_total;
        logic [31:0]      seq_gap_events;
        logic [31:0]      lost_packets;
        logic [31:0]      cc_errors;
        logic [PID_W-1:0] pmt_pid_found;
        logic [PID_W-1:0] pcr_pid_found;
    } t_out_beat;

endpackage

[rtl/rtsm_in_if.sv]
`timescale 1ns / 1ps
interface rtsm_in_if;
    import rtsm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/rtsm_out_if.sv]
`timescale 1ns / 1ps
interface rtsm_out_if;
    import rtsm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/rtp_ts_stream_monitor_core.sv]
`timescale 1ns / 1ps
// Continuity monitor for an MPEG transport stream carried over RTP.
//
// i_in carries one beat per datagram payload byte (func = 0) with first_byte
// marking the start of a datagram, or a report request (func = 1). Only a
// report request produces a beat on o_out: the four saturating totals plus the
// PMT and PCR PIDs learned so far; the totals clear in the same cycle.
//
// Every beat is handled in the cycle it is accepted: the parse state and
// counters update at that edge, and a report lands in the output register,
// so a report is visible on o_out in the cycle after acceptance. Throughput is
// one beat per cycle unless a stalled receiver holds a report; the path that
// sets it is the saturating counter add plus the sequence-number subtract.
//
// TS packet position inside a datagram is tracked by a byte counter and a
// packet counter that advance with the datagram offset.
//
// Reset (i_rst_n low, synchronous) returns all parse state and counters to
// their initial values and empties the output register. When the receiver
// stalls with a report pending, i_in.ready drops until the report is taken;
// one output register separates the two sides, so no beat is ever lost.
module rtp_ts_stream_monitor_core #(
    parameter int TS_PACKET_BYTES = 188,
    parameter int TS_PER_DATAGRAM = 7,
    parameter int COUNTER_BITS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rtsm_in_if.sink           i_in,
    rtsm_out_if.source        o_out
);
    import rtsm_pkg::*;

    localparam int PosW = $clog2(TS_PACKET_BYTES);
    localparam int IdxW = $clog2(TS_PER_DATAGRAM + 1);
    localparam logic [COUNTER_BITS-1:0] CntMax = '1;

    // Saturating add; a carry out of the top means the sum passed all ones.
    function automatic logic [COUNTER_BITS-1:0] sat_add(
        input logic [COUNTER_BITS-1:0] a,
        input logic [15:0]             v
    );
        logic [COUNTER_BITS:0] s;
        s = {1'b0, a} + (COUNTER_BITS+1)'(v);
        return s[COUNTER_BITS] ? CntMax : s[COUNTER_BITS-1:0];
    endfunction

    // parse state
    logic [OFF_W-1:0]        r_off, n_off;
    logic [6:0]              r_hdr, n_hdr;
    logic [7:0]              r_seq_high, n_seq_high;
    logic [15:0]             r_exp_seq, n_exp_seq;
    logic [23:0]             r_ts_hdr, n_ts_hdr;
    logic [7:0]              r_adapt, n_adapt;
    logic [15:0]             r_tword, n_tword;
    logic [3:0]              r_zwc, n_zwc;
    logic [PID_W-1:0]        r_pmt, n_pmt;
    logic [PID_W-1:0]        r_pcr, n_pcr;
    logic [3:0]              r_cc_exp, n_cc_exp;
    logic                    r_cc_start, n_cc_start;
    logic                    r_cc_pend, n_cc_pend;
    logic [PosW-1:0]         r_pkt_pos, n_pkt_pos;
    logic [IdxW-1:0]         r_pkt_idx, n_pkt_idx;
    // totals
    logic [COUNTER_BITS-1:0] r_cnt_bytes, n_cnt_bytes;
    logic [COUNTER_BITS-1:0] r_cnt_gaps, n_cnt_gaps;
    logic [COUNTER_BITS-1:0] r_cnt_lost, n_cnt_lost;
    logic [COUNTER_BITS-1:0] r_cnt_cc, n_cnt_cc;
    // output register
    logic                    r_out_valid;
    t_out_beat               r_out;

    logic                    w_acc, w_acc_rep, w_acc_byte;
    logic [7:0]              w_b;
    logic [OFF_W-1:0]        w_off;
    logic                    w_live;
    logic                    w_at_start;
    logic [PosW-1:0]         w_p;
    logic [IdxW-1:0]         w_idx;
    logic                    w_ts_en;
    logic [15:0]             w_seq, w_seq_exp, w_lost;
    logic [PID_W-1:0]        w_pid;
    logic                    w_cc_en, w_cc_disc;
    logic [3:0]              w_cc, w_cc_ref;
    logic                    w_tab_en;
    logic [PosW-1:0]         w_q;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_acc_rep  = w_acc && i_in.data.func;
    assign w_acc_byte = w_acc && !i_in.data.func;
    assign w_b        = i_in.data.data_byte;

    assign w_off      = i_in.data.first_byte ? '0 : r_off;
    assign w_live     = w_off < OFFSET_MAX;
    // the first TS byte of a datagram sits right after the RTP header
    assign w_at_start = w_off == {4'b0, r_hdr};
    assign w_p        = w_at_start ? '0 : r_pkt_pos;
    assign w_idx      = w_at_start ? '0 : r_pkt_idx;
    assign w_ts_en    = w_acc_byte && w_live && (w_off >= {4'b0, r_hdr})
                        && (w_idx < IdxW'(TS_PER_DATAGRAM));

    assign w_seq      = {r_seq_high, w_b};
    assign w_seq_exp  = (r_exp_seq == 16'd0 && w_seq != 16'd0) ? w_seq
                                                               : r_exp_seq + 16'd1;
    assign w_lost     = w_seq - w_seq_exp;

    assign w_pid      = r_ts_hdr[20:8];
    assign w_cc       = r_ts_hdr[3:0];
    assign w_cc_disc  = (w_p == PosW'(5)) && w_b[7];
    // continuity check at byte 4 if no or an empty adaptation field, else byte 5
    assign w_cc_en    = w_ts_en && (r_pcr != '0) && r_ts_hdr[4] && (w_pid == r_pcr)
                        && (((w_p == PosW'(4)) && (!r_ts_hdr[5] || w_b == 8'd0))
                         || ((w_p == PosW'(5)) && r_ts_hdr[5] && r_adapt != 8'd0));
    assign w_cc_ref   = (!r_cc_start || w_cc_disc) ? w_cc : r_cc_exp;

    assign w_tab_en   = w_ts_en && (r_pcr == '0) && !r_ts_hdr[23] && r_ts_hdr[22]
                        && (w_pid == r_pmt) && (w_p >= PosW'(TABLE_START));
    assign w_q        = w_p - PosW'(TABLE_START);

    always_comb begin
        n_off       = r_off;
        n_hdr       = r_hdr;
        n_seq_high  = r_seq_high;
        n_exp_seq   = r_exp_seq;
        n_ts_hdr    = r_ts_hdr;
        n_adapt     = r_adapt;
        n_tword     = r_tword;
        n_zwc       = r_zwc;
        n_pmt       = r_pmt;
        n_pcr       = r_pcr;
        n_cc_exp    = r_cc_exp;
        n_cc_start  = r_cc_start;
        n_cc_pend   = r_cc_pend;
        n_pkt_pos   = r_pkt_pos;
        n_pkt_idx   = r_pkt_idx;
        n_cnt_bytes = r_cnt_bytes;
        n_cnt_gaps  = r_cnt_gaps;
        n_cnt_lost  = r_cnt_lost;
        n_cnt_cc    = r_cnt_cc;

        if (w_acc_rep) begin
            n_cnt_bytes = '0;
            n_cnt_gaps  = '0;
            n_cnt_lost  = '0;
            n_cnt_cc    = '0;
        end

        if (w_acc_byte) begin
            n_cnt_bytes = sat_add(r_cnt_bytes, 16'd1);
            n_off       = w_live ? w_off + 1'b1 : OFFSET_MAX;

            if (w_live) begin
                case (w_off)
                    11'd0: n_hdr = RTP_HDR_BASE + {1'b0, w_b[3:0], 2'b00};
                    11'd2: n_seq_high = w_b;
                    11'd3: begin
                        // the expected number always ends up at the one received
                        n_exp_seq = w_seq;
                        if (w_seq != w_seq_exp) begin
                            n_cnt_lost = sat_add(r_cnt_lost, w_lost);
                            n_cnt_gaps = sat_add(r_cnt_gaps, 16'd1);
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (w_ts_en) begin
            // advance the TS byte position
            if (w_p == PosW'(TS_PACKET_BYTES - 1)) begin
                n_pkt_pos = '0;
                n_pkt_idx = w_idx + 1'b1;
            end else begin
                n_pkt_pos = w_p + 1'b1;
                n_pkt_idx = w_idx;
            end

            if (w_p == '0) begin
                n_ts_hdr = '0;
                n_adapt  = (w_b == SYNC_BYTE) ? 8'd1 : 8'd0;
                n_zwc    = '0;
            end else if (w_p <= PosW'(3)) begin
                n_ts_hdr = {r_ts_hdr[15:0], w_b};
                // drop the header of a packet with a bad sync byte
                if (w_p == PosW'(3) && r_adapt == 8'd0) begin
                    n_ts_hdr = '0;
                end
            end else if (r_pcr != '0 && w_p == PosW'(4)) begin
                n_adapt = w_b;
            end
        end

        if (w_cc_en) begin
            n_cc_start = 1'b1;
            if (w_cc != w_cc_ref) begin
                if (!r_cc_pend) begin
                    n_cc_pend = 1'b1;
                    n_cc_exp  = w_cc_ref;
                end else begin
                    n_cnt_cc = sat_add(r_cnt_cc, 16'd1);
                    n_cc_exp = w_cc + 4'd1;
                end
            end else begin
                n_cc_pend = 1'b0;
                n_cc_exp  = w_cc_ref + 4'd1;
            end
        end

        if (w_tab_en) begin
            if (r_pmt != '0) begin
                // PMT: PCR PID follows the section header
                if (w_q == '0) begin
                    n_tword = {8'd0, w_b};
                end else if (w_q == PosW'(1)) begin
                    n_pcr = {r_tword[4:0], w_b};
                end
            end else if (r_zwc <= ZERO_LIMIT) begin
                // PAT: walk 4-byte program entries, skip program number 0
                case (w_q[1:0])
                    2'd0: n_tword = {8'd0, w_b};
                    2'd1: begin
                        if ({r_tword[7:0], w_b} == 16'd0) begin
                            n_tword = 16'd0;
                            n_zwc   = r_zwc + 4'd1;
                        end else begin
                            n_tword = 16'h8000;
                        end
                    end
                    2'd2: begin
                        if (r_tword[15]) begin
                            n_tword = {3'b100, w_b[4:0], 8'd0};
                        end
                    end
                    default: begin
                        if (r_tword[15]) begin
                            n_pmt = {r_tword[12:8], w_b};
                            n_zwc = TABLE_DONE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off       <= '0;
            r_hdr       <= RTP_HDR_BASE;
            r_seq_high  <= '0;
            r_exp_seq   <= '0;
            r_ts_hdr    <= '0;
            r_adapt     <= '0;
            r_tword     <= '0;
            r_zwc       <= '0;
            r_pmt       <= '0;
            r_pcr       <= '0;
            r_cc_exp    <= '0;
            r_cc_start  <= 1'b0;
            r_cc_pend   <= 1'b0;
            r_pkt_pos   <= '0;
            r_pkt_idx   <= '0;
            r_cnt_bytes <= '0;
            r_cnt_gaps  <= '0;
            r_cnt_lost  <= '0;
            r_cnt_cc    <= '0;
        end else begin
            r_off       <= n_off;
            r_hdr       <= n_hdr;
            r_seq_high  <= n_seq_high;
            r_exp_seq   <= n_exp_seq;
            r_ts_hdr    <= n_ts_hdr;
            r_adapt     <= n_adapt;
            r_tword     <= n_tword;
            r_zwc       <= n_zwc;
            r_pmt       <= n_pmt;
            r_pcr       <= n_pcr;
            r_cc_exp    <= n_cc_exp;
            r_cc_start  <= n_cc_start;
            r_cc_pend   <= n_cc_pend;
            r_pkt_pos   <= n_pkt_pos;
            r_pkt_idx   <= n_pkt_idx;
            r_cnt_bytes <= n_cnt_bytes;
            r_cnt_gaps  <= n_cnt_gaps;
            r_cnt_lost  <= n_cnt_lost;
            r_cnt_cc    <= n_cnt_cc;
        end
    end

    // hold the report until taken; load a new one on each report request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc_rep) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_rep) begin
            r_out.byte_total     <= 32'(r_cnt_bytes);
            r_out.seq_gap_events <= 32'(r_cnt_gaps);
            r_out.lost_packets   <= 32'(r_cnt_lost);
            r_out.cc_errors      <= 32'(r_cnt_cc);
            r_out.pmt_pid_found  <= r_pmt;
            r_out.pcr_pid_found  <= r_pcr;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_report_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_rep |=> o_out.valid)
        else $error("report beat not presented");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_rep |=> (r_cnt_bytes == '0) && (r_cnt_cc == '0))
        else $error("counters not cleared by report");

    a_first_byte_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_byte && i_in.data.first_byte |=> r_off == 11'd1)
        else $error("datagram offset not restarted");

    a_pkt_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ts_en |=> r_pkt_idx <= IdxW'(TS_PER_DATAGRAM))
        else $error("TS packet index overran");

endmodule

[tb/tb_rtp_ts_stream_monitor_core.sv]
`timescale 1ns / 1ps
module tb_rtp_ts_stream_monitor_core;
    import rtsm_pkg::*;

    localparam int TS_PACKET_BYTES    = 188;
    localparam int TS_PER_DATAGRAM    = 7;
    localparam int COUNTER_BITS       = 32;
    localparam int STALL_LIMIT        = 2000;
    localparam int MAX_PRINTED        = 40;
    localparam int RANDOM_PHASE_BEATS = 250;
    localparam int LONG_DGRAM_BYTES   = 2060;
    localparam int DRAIN_CYCLES       = 5;

    // TS adaptation_field_control codes and header constants
    localparam logic [1:0]  AFC_NONE    = 2'b00;
    localparam logic [1:0]  AFC_PAYLOAD = 2'b01;
    localparam logic [1:0]  AFC_ADAPT   = 2'b10;
    localparam logic [1:0]  AFC_BOTH    = 2'b11;
    localparam logic [12:0] PID_PAT     = 13'd0;
    localparam logic [7:0]  DISC_FLAG   = 8'h80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rtsm_in_if  in_if ();
    rtsm_out_if out_if ();

    rtp_ts_stream_monitor_core #(
        .TS_PACKET_BYTES(TS_PACKET_BYTES),
        .TS_PER_DATAGRAM(TS_PER_DATAGRAM),
        .COUNTER_BITS   (COUNTER_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predicted monitor state: datagram walk, RTP sequence, PSI tables,
    // continuity tracking and the four report totals.
    // ------------------------------------------------------------------
    logic [10:0] mon_offset;
    logic [6:0]  mon_hdr_len;
    logic [7:0]  mon_seq_hi;
    logic [15:0] mon_next_seq;
    logic [23:0] mon_ts_hdr;
    logic [7:0]  mon_af_len;
    logic [15:0] mon_tword;
    logic [3:0]  mon_zero_cnt;
    logic [12:0] mon_pmt_pid;
    logic [12:0] mon_pcr_pid;
    logic [3:0]  mon_cc_next;
    logic        mon_cc_live;
    logic        mon_cc_miss;
    logic [31:0] tot_bytes;
    logic [31:0] tot_gaps;
    logic [31:0] tot_lost;
    logic [31:0] tot_cc;

    t_out_beat   pending_reports[$];
    int          err_count = 0;
    int          quiet_cycles = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;

    // Stimulus generator state
    logic [7:0]  dgram[$];
    logic [15:0] gen_seq;
    logic [3:0]  gen_cc;

    function automatic logic [31:0] sat_inc(input logic [31:0] acc, input logic [31:0] amount);
        logic [32:0] sum;
        sum = {1'b0, acc} + {1'b0, amount};
        return sum[32] ? '1 : sum[31:0];
    endfunction

    function automatic logic [7:0] rnd8();
        logic [7:0] r;
        r = $urandom_range(0, 255);
        return r;
    endfunction

    task automatic clear_monitor();
        mon_offset   = '0;
        mon_hdr_len  = RTP_HDR_BASE;
        mon_seq_hi   = '0;
        mon_next_seq = '0;
        mon_ts_hdr   = '0;
        mon_af_len   = '0;
        mon_tword    = '0;
        mon_zero_cnt = '0;
        mon_pmt_pid  = '0;
        mon_pcr_pid  = '0;
        mon_cc_next  = '0;
        mon_cc_live  = 1'b0;
        mon_cc_miss  = 1'b0;
        tot_bytes    = '0;
        tot_gaps     = '0;
        tot_lost     = '0;
        tot_cc       = '0;
    endtask

    // Zero expected sequence with a nonzero arrival: adopt it, no gap.
    task automatic track_rtp_seq(input logic [7:0] lo);
        logic [15:0] seq;
        logic [15:0] diff;
        seq = {mon_seq_hi, lo};
        if (mon_next_seq == 16'd0 && seq != 16'd0)
            mon_next_seq = seq;
        else
            mon_next_seq = mon_next_seq + 16'd1;
        if (seq != mon_next_seq) begin
            diff = seq - mon_next_seq;
            tot_lost = sat_inc(tot_lost, {16'd0, diff});
            tot_gaps = sat_inc(tot_gaps, 32'd1);
            mon_next_seq = seq;
        end
    endtask

    // Count a CC error only when the mismatch repeats on the next packet.
    task automatic track_pcr_cc(input logic disc);
        logic [3:0] cc;
        if (!mon_ts_hdr[4] || mon_ts_hdr[20:8] != mon_pcr_pid)
            return;
        cc = mon_ts_hdr[3:0];
        if (!mon_cc_live || disc) begin
            mon_cc_next = cc;
            mon_cc_live = 1'b1;
        end
        if (cc != mon_cc_next) begin
            if (!mon_cc_miss) begin
                mon_cc_miss = 1'b1;
            end else begin
                tot_cc = sat_inc(tot_cc, 32'd1);
                mon_cc_next = cc + 4'd1;
            end
        end else begin
            mon_cc_miss = 1'b0;
            mon_cc_next = mon_cc_next + 4'd1;
        end
    endtask

    // PAT walk while no PMT PID is known, then the PCR PID out of the PMT.
    task automatic parse_psi_byte(input int unsigned p, input logic [7:0] b);
        int unsigned q;
        if (mon_ts_hdr[23] || !mon_ts_hdr[22] || mon_ts_hdr[20:8] != mon_pmt_pid)
            return;
        if (p < TABLE_START)
            return;
        q = p - TABLE_START;
        if (mon_pmt_pid != '0) begin
            if (q == 0)
                mon_tword = {8'd0, b};
            else if (q == 1)
                mon_pcr_pid = {mon_tword[4:0], b};
            return;
        end
        if (mon_zero_cnt > ZERO_LIMIT)
            return;
        case (q % 4)
            0: mon_tword = {8'd0, b};
            1: begin
                mon_tword = {mon_tword[7:0], b};
                if (mon_tword == 16'd0)
                    mon_zero_cnt = mon_zero_cnt + 4'd1;
                else
                    mon_tword = 16'h8000;
            end
            2: if (mon_tword[15]) mon_tword = {1'b1, 2'b00, b[4:0], 8'h00};
            default: if (mon_tword[15]) begin
                mon_pmt_pid  = {mon_tword[12:8], b};
                mon_zero_cnt = TABLE_DONE;
            end
        endcase
    endtask

    task automatic walk_ts_byte(input int unsigned p, input logic [7:0] b);
        logic [23:0] h;
        h = mon_ts_hdr;
        if (p == 0) begin
            // the adaptation length register doubles as the sync-ok flag here
            mon_ts_hdr   = '0;
            mon_af_len   = (b == SYNC_BYTE) ? 8'd1 : 8'd0;
            mon_zero_cnt = '0;
            return;
        end
        if (p <= 3) begin
            mon_ts_hdr = {h[15:0], b};
            if (p == 3 && mon_af_len == 8'd0)
                mon_ts_hdr = '0;
            return;
        end
        if (mon_pcr_pid != '0) begin
            if (p == 4) begin
                mon_af_len = b;
                if (!h[5] || b == 8'd0)
                    track_pcr_cc(1'b0);
            end else if (p == 5 && h[5] && mon_af_len != 8'd0) begin
                track_pcr_cc(b[7]);
            end
            return;
        end
        parse_psi_byte(p, b);
    endtask

    // Advance the predicted monitor by one accepted input beat.
    task automatic predict_monitor(input t_in_beat beat);
        logic [10:0] off;
        int unsigned rel;
        if (beat.func) begin
            pending_reports.push_back(t_out_beat'{
                byte_total:     tot_bytes,
                seq_gap_events: tot_gaps,
                lost_packets:   tot_lost,
                cc_errors:      tot_cc,
                pmt_pid_found:  mon_pmt_pid,
                pcr_pid_found:  mon_pcr_pid});
            tot_bytes = '0;
            tot_gaps  = '0;
            tot_lost  = '0;
            tot_cc    = '0;
            return;
        end
        off = beat.first_byte ? '0 : mon_offset;
        tot_bytes = sat_inc(tot_bytes, 32'd1);
        if (off < OFFSET_MAX) begin
            if (off == 11'd0)
                mon_hdr_len = RTP_HDR_BASE + {1'b0, beat.data_byte[3:0], 2'b00};
            else if (off == 11'd2)
                mon_seq_hi = beat.data_byte;
            else if (off == 11'd3)
                track_rtp_seq(beat.data_byte);
            if (off >= mon_hdr_len) begin
                rel = off - mon_hdr_len;
                if (rel < TS_PER_DATAGRAM * TS_PACKET_BYTES)
                    walk_ts_byte(rel % TS_PACKET_BYTES, beat.data_byte);
            end
        end
        mon_offset = (off < OFFSET_MAX) ? off + 11'd1 : OFFSET_MAX;
    endtask

    // ------------------------------------------------------------------
    // Handshake side: sender, receiver, checker, watchdog
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("%0t: %s mismatch, got 0x%08h, expected 0x%08h", $time, what, got, want);
    endtask

    // Hold valid with the beat until accepted; idle first at the sender rate.
    task automatic send_beat(input t_in_beat beat);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= beat;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        predict_monitor(beat);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first);
        send_beat(t_in_beat'{func: 1'b0, data_byte: b, first_byte: first});
    endtask

    // Payload fields of a report beat are don't-care; randomize them.
    task automatic send_report();
        logic [7:0] junk;
        junk = rnd8();
        send_beat(t_in_beat'{func: 1'b1, data_byte: junk, first_byte: junk[0]});
    endtask

    // Drop valid and hold off until every report has come back.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_reports.size() != 0);
    endtask

    task automatic send_datagram(input bit mid_reports);
        foreach (dgram[i]) begin
            if (mid_reports && $urandom_range(0, 29) == 0)
                send_report();
            send_byte(dgram[i], i == 0);
        end
    endtask

    always @(posedge i_clk)
        out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge i_clk) begin : check_reports
        t_out_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected report beat", '0, '0);
            end else begin
                want = pending_reports.pop_front();
                if (out_if.data.byte_total !== want.byte_total)
                    report_mismatch("byte_total", out_if.data.byte_total, want.byte_total);
                if (out_if.data.seq_gap_events !== want.seq_gap_events)
                    report_mismatch("seq_gap_events", out_if.data.seq_gap_events,
                                    want.seq_gap_events);
                if (out_if.data.lost_packets !== want.lost_packets)
                    report_mismatch("lost_packets", out_if.data.lost_packets,
                                    want.lost_packets);
                if (out_if.data.cc_errors !== want.cc_errors)
                    report_mismatch("cc_errors", out_if.data.cc_errors, want.cc_errors);
                if (out_if.data.pmt_pid_found !== want.pmt_pid_found)
                    report_mismatch("pmt_pid_found", {19'd0, out_if.data.pmt_pid_found},
                                    {19'd0, want.pmt_pid_found});
                if (out_if.data.pcr_pid_found !== want.pcr_pid_found)
                    report_mismatch("pcr_pid_found", {19'd0, out_if.data.pcr_pid_found},
                                    {19'd0, want.pcr_pid_found});
            end
        end
    end

    // End the run when neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("rtp_ts_stream_monitor_core test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datagram builders (fill dgram)
    // ------------------------------------------------------------------

    // Advance the RTP sequence, with the odd jump, repeat or wrap.
    task automatic push_rtp_header();
        logic [3:0]  csrc;
        logic [7:0]  r;
        int unsigned roll;
        csrc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            gen_seq = $urandom_range(0, 65535);
        else if (roll == 1)
            gen_seq = 16'hFFFF - $urandom_range(0, 2);
        else if (roll != 2)
            gen_seq = gen_seq + 16'd1;
        r = rnd8();
        dgram.push_back({r[7:4], csrc});
        dgram.push_back(rnd8());
        dgram.push_back(gen_seq[15:8]);
        dgram.push_back(gen_seq[7:0]);
        repeat (8 + 4 * csrc)
            dgram.push_back(rnd8());
    endtask

    task automatic push_ts_header(input bit clean, input logic [12:0] pid, input logic pusi,
                                  input logic [1:0] afc, input logic [3:0] cc);
        logic [7:0] sync;
        logic [7:0] r;
        logic       tei;
        sync = SYNC_BYTE;
        tei  = 1'b0;
        if (!clean) begin
            if ($urandom_range(0, 11) == 0)
                sync = rnd8();
            tei = ($urandom_range(0, 9) == 0);
        end
        r = rnd8();
        dgram.push_back(sync);
        dgram.push_back({tei, pusi, r[0], pid[12:8]});
        dgram.push_back(pid[7:0]);
        dgram.push_back({r[7:6], afc, cc});
    endtask

    // PAT: a run of zero program entries (sometimes past the give-up count)
    // followed by one real entry whose PID is occasionally zero.
    task automatic build_pat();
        logic [12:0] pid;
        logic [12:0] found;
        logic [15:0] prog;
        logic [7:0]  r;
        int unsigned zeros;
        push_rtp_header();
        pid = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : PID_PAT;
        push_ts_header(1'b0, pid, $urandom_range(0, 7) != 0, AFC_PAYLOAD,
                       $urandom_range(0, 15));
        repeat (TABLE_START - 4)
            dgram.push_back(rnd8());
        case ($urandom_range(0, 2))
            0: zeros = $urandom_range(11, 12);
            1: zeros = $urandom_range(0, 2);
            default: zeros = $urandom_range(3, 10);
        endcase
        repeat (zeros) begin
            dgram.push_back(8'h00);
            dgram.push_back(8'h00);
            dgram.push_back(rnd8());
            dgram.push_back(rnd8());
        end
        prog  = $urandom_range(1, 65535);
        found = ($urandom_range(0, 5) == 0) ? 13'd0 : $urandom_range(1, 8191);
        r     = rnd8();
        dgram.push_back(prog[15:8]);
        dgram.push_back(prog[7:0]);
        dgram.push_back({r[7:5], found[12:8]});
        dgram.push_back(found[7:0]);
        repeat ($urandom_range(0, 4))
            dgram.push_back(rnd8());
    endtask

    task automatic build_pmt();
        logic [12:0] pid;
        logic [12:0] pcr;
        logic [7:0]  r;
        push_rtp_header();
        pid = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : mon_pmt_pid;
        push_ts_header(1'b0, pid, $urandom_range(0, 7) != 0, AFC_PAYLOAD,
                       $urandom_range(0, 15));
        repeat (TABLE_START - 4)
            dgram.push_back(rnd8());
        pcr = ($urandom_range(0, 7) == 0) ? 13'd0 : $urandom_range(1, 8191);
        r   = rnd8();
        dgram.push_back({r[7:5], pcr[12:8]});
        dgram.push_back(pcr[7:0]);
        repeat ($urandom_range(0, 4))
            dgram.push_back(rnd8());
    endtask

    // One packet prefix on the PCR PID: CC mostly in step, with repeats,
    // skips and jumps; every adaptation field shape, discontinuity at times.
    task automatic build_cc();
        logic [12:0] pid;
        logic [1:0]  afc;
        logic [3:0]  cc;
        logic [7:0]  flags;
        push_rtp_header();
        pid = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : mon_pcr_pid;
        afc = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
            0: cc = gen_cc;
            1: cc = $urandom_range(0, 15);
            2: cc = gen_cc + 4'd2;
            default: cc = gen_cc + 4'd1;
        endcase
        gen_cc = cc;
        push_ts_header(1'b0, pid, $urandom_range(0, 1), afc, cc);
        dgram.push_back(($urandom_range(0, 4) == 0) ? 8'd0 : $urandom_range(1, 183));
        flags = rnd8();
        flags[7] = ($urandom_range(0, 5) == 0);
        dgram.push_back(flags);
        repeat ($urandom_range(0, 3))
            dgram.push_back(rnd8());
    endtask

    task automatic build_noise();
        push_rtp_header();
        repeat ($urandom_range(0, 24))
            dgram.push_back(rnd8());
    endtask

    task automatic push_pcr_packet(input logic [1:0] afc, input logic [3:0] cc,
                                   input logic [7:0] af_len, input logic [7:0] flags);
        push_ts_header(1'b1, mon_pcr_pid, 1'b0, afc, cc);
        dgram.push_back(af_len);
        dgram.push_back(flags);
        repeat (TS_PACKET_BYTES - 6)
            dgram.push_back(rnd8());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_report();
        send_report();
    endtask

    // Bytes before any first_byte mark start a datagram at offset zero;
    // sequence zero right after reset is a full-range gap.
    task automatic test_unmarked_start();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_report();
    endtask

    // Largest CSRC count, sequence adoption, forward gap, backward gap,
    // then two reports back to back to see the clear.
    task automatic test_sequence_rules();
        dgram = '{8'hFF, 8'h00, 8'h12, 8'h34};
        send_datagram(1'b0);
        dgram = '{8'h80, 8'hFF, 8'h12, 8'h36};
        send_datagram(1'b0);
        dgram = '{8'h80, 8'h60, 8'h12, 8'h35};
        send_datagram(1'b0);
        send_report();
        send_report();
        wait_drained();
    endtask

    // Mostly well-formed datagrams driven by how far table learning got,
    // with noise, truncation and reports mixed in.
    task automatic test_random_phase(input int src_pct, input int snk_pct);
        int unsigned sent;
        src_idle_pct  = src_pct;
        sink_idle_pct = snk_pct;
        sent = 0;
        while (sent < RANDOM_PHASE_BEATS) begin
            dgram.delete();
            if ($urandom_range(0, 9) == 0)
                build_noise();
            else if (mon_pmt_pid == '0)
                build_pat();
            else if (mon_pcr_pid == '0)
                build_pmt();
            else
                build_cc();
            if ($urandom_range(0, 9) == 0)
                dgram = dgram[0:$urandom_range(1, dgram.size()) - 1];
            send_datagram(1'b1);
            sent += dgram.size();
            if ($urandom_range(0, 1) == 0)
                send_report();
            if ($urandom_range(0, 14) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Seven full packets with a discontinuity resync, a zero-length
    // adaptation field and a confirmed CC error, then bytes past the last
    // packet and past the offset ceiling.
    task automatic test_long_datagram();
        logic [3:0] c;
        dgram.delete();
        c = gen_cc + 4'd1;
        push_rtp_header();
        push_pcr_packet(AFC_PAYLOAD, c, rnd8(), rnd8());
        push_pcr_packet(AFC_BOTH, c + 4'd1, 8'd7, 8'h00);
        push_pcr_packet(AFC_PAYLOAD, c + 4'd5, rnd8(), rnd8());
        push_pcr_packet(AFC_BOTH, c + 4'd9, 8'd1, DISC_FLAG);
        push_pcr_packet(AFC_BOTH, c + 4'd10, 8'd0, rnd8());
        push_pcr_packet(AFC_PAYLOAD, c + 4'd3, rnd8(), rnd8());
        push_pcr_packet(AFC_PAYLOAD, c + 4'd4, rnd8(), rnd8());
        gen_cc = c + 4'd4;
        while (dgram.size() < LONG_DGRAM_BYTES)
            dgram.push_back(rnd8());
        send_datagram(1'b0);
        send_report();
        wait_drained();
    endtask

    initial begin
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        i_rst_n      <= 1'b0;
        gen_seq       = $urandom_range(0, 65535);
        gen_cc        = $urandom_range(0, 15);
        clear_monitor();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 36;
        sink_idle_pct = 86;
        test_reset_report();
        test_unmarked_start();
        test_sequence_rules();

        test_random_phase(36, 86);
        test_random_phase(86, 36);
        test_random_phase(0, 0);

        test_long_datagram();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_reports.size() == 0)
            $display("rtp_ts_stream_monitor_core test passed");
        else
            $display("rtp_ts_stream_monitor_core test failed");
        $finish;
    end

endmodule
